[hdl/siphash_pkg.sv]
// Shared types, constants and the SipRound function for the SipHash-2-4 byte stream block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package siphash_pkg;

  localparam logic [63:0] INIT_ZERO  = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_ONE   = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_TWO   = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_THREE = 64'h7465646279746573;
  localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 4'd1;

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Sequencer steps of the back end.
  localparam logic [2:0] STEP_W0   = 3'd0;
  localparam logic [2:0] STEP_W1   = 3'd1;
  localparam logic [2:0] STEP_F0   = 3'd2;
  localparam logic [2:0] STEP_F1   = 3'd3;
  localparam logic [2:0] STEP_LAST = 3'd7;

  typedef struct packed {
    logic        has_word;
    logic [63:0] word;
    logic        is_final;
    logic [63:0] fin_word;
  } job_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  function automatic lanes_t init_lanes(input logic [63:0] k0, input logic [63:0] k1);
    lanes_t l;
    l.v0 = k0 ^ INIT_ZERO;
    l.v1 = k1 ^ INIT_ONE;
    l.v2 = k0 ^ INIT_TWO;
    l.v3 = k1 ^ INIT_THREE;
    return l;
  endfunction

  function automatic lanes_t sip_round(input lanes_t l);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    lanes_t r;
    a = l.v0;
    b = l.v1;
    c = l.v2;
    d = l.v3;
    a = a + b;
    b = {b[50:0], b[63:51]} ^ a;
    a = {a[31:0], a[63:32]};
    c = c + d;
    d = {d[47:0], d[63:48]} ^ c;
    a = a + d;
    d = {d[42:0], d[63:43]} ^ a;
    c = c + b;
    b = {b[46:0], b[63:47]} ^ c;
    c = {c[31:0], c[63:32]};
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/siphash_in_if.sv]
// Input channel of the SipHash block: one optional byte and an end mark per request.
// No dependencies.
`default_nettype none
interface siphash_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface
`default_nettype wire

[hdl/siphash_out_if.sv]
// Result channel of the SipHash block: one 64-bit hash per message.
// No dependencies.
`default_nettype none
interface siphash_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

[hdl/siphash_cfg_if.sv]
// Configuration write channel of the SipHash block: register index and data.
// Index width comes from siphash_pkg.
`default_nettype none
interface siphash_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [siphash_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/siphash_front.sv]
// Front end: accepts byte requests, packs bytes into words, tracks the length
// and pushes compression jobs. Depends on siphash_pkg and siphash_in_if.
`default_nettype none
module siphash_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  siphash_in_if.sink             in_chan,
  input  wire logic              key_load,
  input  wire logic              q_full,
  output logic                   q_push,
  output siphash_pkg::job_t      q_job
);

  logic [55:0] partial_r, partial_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [7:0]  len_r, len_nxt;

  logic        accept;
  logic [7:0]  len_p;
  logic [55:0] partial_p;
  logic [2:0]  held_p;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    len_p     = len_r;
    partial_p = partial_r;
    held_p    = held_r;
    q_job     = '0;
    if (in_chan.byte_present) begin
      len_p = len_r + 8'd1;
      if (held_r == 3'd7) begin
        q_job.has_word = 1'b1;
        q_job.word     = {in_chan.data_byte, partial_r};
        partial_p      = '0;
        held_p         = 3'd0;
      end else begin
        // Bytes above the held count are zero; the new byte is written at the held count.
        for (int i = 0; i < 7; i++) begin
          if (held_r == 3'(i)) begin
            partial_p[8*i +: 8] = in_chan.data_byte;
          end
        end
        held_p = held_r + 3'd1;
      end
    end
    q_job.is_final = in_chan.end_of_message;
    q_job.fin_word = {len_p, partial_p};
  end

  assign q_push = accept && (q_job.has_word || q_job.is_final);

  always_comb begin
    partial_nxt = partial_r;
    held_nxt    = held_r;
    len_nxt     = len_r;
    if (key_load || (accept && in_chan.end_of_message)) begin
      partial_nxt = '0;
      held_nxt    = 3'd0;
      len_nxt     = 8'd0;
    end else if (accept) begin
      partial_nxt = partial_p;
      held_nxt    = held_p;
      len_nxt     = len_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      held_r    <= 3'd0;
      len_r     <= 8'd0;
    end else begin
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/siphash_queue.sv]
// Short job queue between the front and back ends.
// Depends on siphash_pkg for the job type and depth.
`default_nettype none
module siphash_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire siphash_pkg::job_t push_job,
  input  wire logic              pop,
  output siphash_pkg::job_t      head_job,
  output logic                   valid,
  output logic                   full
);

  siphash_pkg::job_t entries_r [siphash_pkg::QDEPTH];
  logic [siphash_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [siphash_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [siphash_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push;
  logic do_pop;

  assign valid    = (count_r != '0);
  assign full     = (count_r == siphash_pkg::QCNT_W'(siphash_pkg::QDEPTH));
  assign head_job = entries_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/siphash_back.sv]
// Back end: holds the keys and four lanes, runs one SipRound per cycle on queued
// jobs while no untaken hash stalls it, and registers the hash. Depends on siphash_pkg and siphash_out_if.
`default_nettype none
module siphash_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire siphash_pkg::cfg_wr_t cfg_wr,
  input  wire siphash_pkg::job_t    job,
  input  wire logic                 job_valid,
  output logic                      job_pop,
  siphash_out_if.source             out_chan
);

  logic [63:0] key0_r, key0_nxt;
  logic [63:0] key1_r, key1_nxt;
  siphash_pkg::lanes_t lanes_r, lanes_nxt;
  siphash_pkg::job_t   cur_r, cur_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hash_r, hash_nxt;

  logic        key_load;
  logic [63:0] pre3;
  logic [63:0] post0;
  logic [63:0] post2;
  siphash_pkg::lanes_t rin;
  siphash_pkg::lanes_t rout;
  logic        last_step;
  logic        stall;
  logic        advance;

  assign key_load = cfg_wr.valid && (cfg_wr.index == siphash_pkg::REG_KEY_LOW ||
                                     cfg_wr.index == siphash_pkg::REG_KEY_HIGH);
  assign key0_nxt = (cfg_wr.valid && cfg_wr.index == siphash_pkg::REG_KEY_LOW) ?
                    cfg_wr.data : key0_r;
  assign key1_nxt = (cfg_wr.valid && cfg_wr.index == siphash_pkg::REG_KEY_HIGH) ?
                    cfg_wr.data : key1_r;

  // Word xor into lane three before the first round of a compression, into
  // lane zero after the second; the final mark goes in with the final word.
  always_comb begin
    pre3  = '0;
    post0 = '0;
    post2 = '0;
    case (step_r)
      siphash_pkg::STEP_W0: pre3 = cur_r.word;
      siphash_pkg::STEP_W1: post0 = cur_r.word;
      siphash_pkg::STEP_F0: pre3 = cur_r.fin_word;
      siphash_pkg::STEP_F1: begin
        post0 = cur_r.fin_word;
        post2 = siphash_pkg::FINAL_MARK;
      end
      default: ;
    endcase
    rin    = lanes_r;
    rin.v3 = lanes_r.v3 ^ pre3;
    rout    = siphash_pkg::sip_round(rin);
    rout.v0 = rout.v0 ^ post0;
    rout.v2 = rout.v2 ^ post2;
  end

  assign last_step = (step_r == siphash_pkg::STEP_W1 && !cur_r.is_final) ||
                     (step_r == siphash_pkg::STEP_LAST);
  assign stall   = busy_r && (step_r == siphash_pkg::STEP_LAST) &&
                   out_valid_r && !out_chan.ready;
  assign advance = busy_r && !stall;
  assign job_pop = (!busy_r || (advance && last_step)) && job_valid;

  always_comb begin
    lanes_nxt     = lanes_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    if (key_load) begin
      lanes_nxt = siphash_pkg::init_lanes(key0_nxt, key1_nxt);
    end else if (advance) begin
      if (step_r == siphash_pkg::STEP_LAST) begin
        lanes_nxt = siphash_pkg::init_lanes(key0_r, key1_r);
      end else begin
        lanes_nxt = rout;
      end
    end

    if (advance && step_r == siphash_pkg::STEP_LAST) begin
      hash_nxt      = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
      out_valid_nxt = 1'b1;
    end

    if (job_pop) begin
      cur_nxt  = job;
      busy_nxt = 1'b1;
      step_nxt = job.has_word ? siphash_pkg::STEP_W0 : siphash_pkg::STEP_F0;
    end else if (advance && last_step) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      step_nxt = step_r + 3'd1;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = hash_r;

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    hash_r <= hash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r      <= '0;
      key1_r      <= '0;
      lanes_r     <= siphash_pkg::init_lanes(64'd0, 64'd0);
      step_r      <= siphash_pkg::STEP_W0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key0_r      <= key0_nxt;
      key1_r      <= key1_nxt;
      lanes_r     <= lanes_nxt;
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/siphash_2_4_byte_stream.sv]
// Top level of the keyed SipHash-2-4 byte stream block: front end, job queue
// and back end. Depends on siphash_pkg, the three channel interfaces and the submodules.
//
//   channel   role    payload                                     width
//   in_chan   sink    data_byte, byte_present, end_of_message      8+1+1
//   out_chan  source  hash_value                                  64
//   cfg_chan  sink    index (0 key_low, 1 key_high), data         4+64
//
// The front end takes one request per cycle while the four-entry job queue has room.
// The back end runs one SipRound per cycle when not stalled: two rounds per full eight-byte word, six
// for the final word and finalization (eight when the last byte also fills a word).
// A hash appears in the cycle after its last round; if the output register still
// holds an untaken hash the back end waits on its last round, and the queue backs
// up into in_chan. Reset is synchronous; it clears the keys, queue and counters and
// loads the lanes from the zero key. cfg_chan is always ready; a key write reloads the lanes.
`default_nettype none
module siphash_2_4_byte_stream (
  input  wire logic   clk,
  input  wire logic   rst_n,
  siphash_in_if.sink  in_chan,
  siphash_out_if.source out_chan,
  siphash_cfg_if.sink cfg_chan
);

  siphash_pkg::cfg_wr_t cfg_wr;
  siphash_pkg::job_t    push_job;
  siphash_pkg::job_t    head_job;
  logic q_push;
  logic q_pop;
  logic q_valid;
  logic q_full;
  logic key_load;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.valid   = cfg_chan.valid;
  assign cfg_wr.index   = cfg_chan.index;
  assign cfg_wr.data    = cfg_chan.data;
  assign key_load = cfg_chan.valid && (cfg_chan.index == siphash_pkg::REG_KEY_LOW ||
                                       cfg_chan.index == siphash_pkg::REG_KEY_HIGH);

  siphash_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .key_load (key_load),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  siphash_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .valid    (q_valid),
    .full     (q_full)
  );

  siphash_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .job       (head_job),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .out_chan  (out_chan)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  // The back end only takes a job that is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  // A request that ends a message always leaves a job queued for the next cycle.
  a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.end_of_message) |=> q_valid)
    else $error("message end left no queued job");

endmodule
`default_nettype wire

[sim/tb_siphash_2_4_byte_stream.sv]
// Self-checking testbench for the keyed SipHash-2-4 byte stream block.
// Depends on siphash_pkg, the three channel interfaces and siphash_2_4_byte_stream.
`timescale 1ns / 1ps

module tb_siphash_2_4_byte_stream;

  localparam int DRAIN_CYCLES     = 64;
  localparam int RECV_HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE  = 200;
  localparam int LONG_MSG_SERIAL  = 5;
  localparam int NOISE_PCT        = 8;
  localparam logic [siphash_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW = 4'd2;
  localparam logic [siphash_pkg::CFG_IDX_W-1:0] REG_SPARE_TOP = 4'd15;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [7:0]                        data_byte;
    logic                              byte_present;
    logic                              end_mark;
    logic                              known;
    logic [63:0]                       known_hash;
    logic [siphash_pkg::CFG_IDX_W-1:0] reg_index;
    logic [63:0]                       reg_data;
  } stim_row_t;

  logic clk;
  logic rst_n;

  siphash_in_if  in_if ();
  siphash_out_if out_if ();
  siphash_cfg_if cfg_if ();

  siphash_2_4_byte_stream u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Predictor state: keys, lanes and the word being gathered.
  logic [63:0] key_word_lo;
  logic [63:0] key_word_hi;
  logic [63:0] st_v0, st_v1, st_v2, st_v3;
  logic [55:0] gather_word;
  logic [2:0]  gather_count;
  logic [7:0]  msg_len_byte;

  logic [63:0] hash_expected_q[$];
  logic [63:0] hash_want;
  stim_row_t   stim_rows[$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int msg_serial     = 0;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic void sip_mix();
    st_v0 = st_v0 + st_v1;
    st_v1 = rotl(st_v1, 13) ^ st_v0;
    st_v0 = rotl(st_v0, 32);
    st_v2 = st_v2 + st_v3;
    st_v3 = rotl(st_v3, 16) ^ st_v2;
    st_v0 = st_v0 + st_v3;
    st_v3 = rotl(st_v3, 21) ^ st_v0;
    st_v2 = st_v2 + st_v1;
    st_v1 = rotl(st_v1, 17) ^ st_v2;
    st_v2 = rotl(st_v2, 32);
  endfunction

  function automatic void compress_word(input logic [63:0] w);
    st_v3 = st_v3 ^ w;
    sip_mix();
    sip_mix();
    st_v0 = st_v0 ^ w;
  endfunction

  function automatic void reload_lanes();
    st_v0        = key_word_lo ^ siphash_pkg::INIT_ZERO;
    st_v1        = key_word_hi ^ siphash_pkg::INIT_ONE;
    st_v2        = key_word_lo ^ siphash_pkg::INIT_TWO;
    st_v3        = key_word_hi ^ siphash_pkg::INIT_THREE;
    gather_word  = '0;
    gather_count = '0;
    msg_len_byte = '0;
  endfunction

  function automatic void apply_reg_write(input logic [siphash_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [63:0] data);
    if (idx == siphash_pkg::REG_KEY_LOW) begin
      key_word_lo = data;
      reload_lanes();
    end else if (idx == siphash_pkg::REG_KEY_HIGH) begin
      key_word_hi = data;
      reload_lanes();
    end
  endfunction

  function automatic void siphash_predict(input logic [7:0] b, input logic p, input logic e,
                                          output logic got, output logic [63:0] h);
    got = 1'b0;
    h   = '0;
    if (p) begin
      msg_len_byte = msg_len_byte + 8'd1;
      if (gather_count == 3'd7) begin
        compress_word({b, gather_word});
        gather_word  = '0;
        gather_count = '0;
      end else begin
        gather_word[8*gather_count +: 8] = b;
        gather_count = gather_count + 3'd1;
      end
    end
    if (e) begin
      compress_word({msg_len_byte, gather_word});
      st_v2 = st_v2 ^ siphash_pkg::FINAL_MARK;
      repeat (4) sip_mix();
      h   = st_v0 ^ st_v1 ^ st_v2 ^ st_v3;
      got = 1'b1;
      reload_lanes();
    end
  endfunction

  function automatic stim_row_t item_row(input logic [7:0] b, input logic p, input logic e,
                                         input logic k, input logic [63:0] h);
    stim_row_t r;
    r              = '0;
    r.kind         = ROW_ITEM;
    r.data_byte    = b;
    r.byte_present = p;
    r.end_mark     = e;
    r.known        = k;
    r.known_hash   = h;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [siphash_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [63:0] data);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.reg_index = idx;
    r.reg_data  = data;
    return r;
  endfunction

  // Offers one request and books its expected hash once it is accepted.
  task automatic offer_item(input logic [7:0] b, input logic p, input logic e,
                            input logic k, input logic [63:0] kh);
    logic        got;
    logic [63:0] h;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.byte_present   <= p;
    in_if.end_of_message <= e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    siphash_predict(b, p, e, got, h);
    if (got) hash_expected_q.push_back(k ? kh : h);
  endtask

  // Key writes happen only once the block has drained.
  task automatic write_reg(input logic [siphash_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    in_if.valid <= 1'b0;
    while (hash_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, data);
  endtask

  task automatic run_random_messages(input int item_goal);
    int   offered;
    int   msg_len;
    logic join_end;
    offered = 0;
    while (offered < item_goal) begin
      msg_len  = (msg_serial == LONG_MSG_SERIAL) ? $urandom_range(300, 256)
                                                 : $urandom_range(24, 0);
      join_end = 1'($urandom_range(1, 0));
      for (int i = 0; i < msg_len; i++) begin
        if ($urandom_range(99, 0) < NOISE_PCT)
          offer_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0, '0);
        offer_item(8'($urandom_range(255, 0)), 1'b1, join_end && (i == msg_len - 1),
                   1'b0, '0);
      end
      if (!join_end || msg_len == 0) begin
        offer_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, 1'b0, '0);
        offered++;
      end
      offered += msg_len;
      msg_serial++;
    end
    // An unfinished message is left behind; the next key write drops it.
    msg_len = $urandom_range(10, 1);
    for (int i = 0; i < msg_len; i++)
      offer_item(8'($urandom_range(255, 0)), 1'b1, 1'b0, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served  <= hold_served + 1;
        hold_left    <= RECV_HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (hash_expected_q.size() == 0) begin
        $error("hash_value: no request pending, actual %h", out_if.hash_value);
        mismatch_count++;
      end else begin
        hash_want = hash_expected_q.pop_front();
        if (out_if.hash_value !== hash_want) begin
          $error("hash_value mismatch: expected %h, actual %h", hash_want, out_if.hash_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.data_byte      <= '0;
    in_if.byte_present   <= 1'b0;
    in_if.end_of_message <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    key_word_lo = '0;
    key_word_hi = '0;
    reload_lanes();

    // Directed part. Published SipHash-2-4 vectors use key bytes 00..0f.
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b0, '0));
    stim_rows.push_back(item_row(8'hff, 1'b0, 1'b0, 1'b0, '0));
    stim_rows.push_back(item_row(8'hff, 1'b1, 1'b1, 1'b0, '0));
    stim_rows.push_back(cfg_row(siphash_pkg::REG_KEY_LOW, 64'h0706050403020100));
    stim_rows.push_back(cfg_row(siphash_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908));
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31));
    for (int b = 0; b < 15; b++) begin
      stim_rows.push_back(item_row(8'(b), 1'b1, b == 14, b == 14, 64'ha129ca6149be45e5));
      if (b == 6) stim_rows.push_back(item_row(8'h5a, 1'b0, 1'b0, 1'b0, '0));
    end
    // A write to an unused index must not disturb the message in flight.
    stim_rows.push_back(item_row(8'h80, 1'b1, 1'b0, 1'b0, '0));
    stim_rows.push_back(cfg_row(REG_SPARE_TOP, '1));
    stim_rows.push_back(item_row(8'h7f, 1'b1, 1'b1, 1'b0, '0));
    stim_rows.push_back(cfg_row(siphash_pkg::REG_KEY_LOW, '1));
    stim_rows.push_back(cfg_row(siphash_pkg::REG_KEY_HIGH, '1));
    stim_rows.push_back(item_row(8'hff, 1'b1, 1'b1, 1'b0, '0));
    // A key write in mid-message drops the bytes gathered so far.
    stim_rows.push_back(item_row(8'h01, 1'b1, 1'b0, 1'b0, '0));
    stim_rows.push_back(item_row(8'hfe, 1'b1, 1'b0, 1'b0, '0));
    stim_rows.push_back(cfg_row(siphash_pkg::REG_KEY_LOW, '0));
    stim_rows.push_back(item_row(8'h00, 1'b0, 1'b1, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 9;
    recv_idle_pct <= 54;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_ITEM)
        offer_item(stim_rows[i].data_byte, stim_rows[i].byte_present, stim_rows[i].end_mark,
                   stim_rows[i].known, stim_rows[i].known_hash);
      else
        write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
    end

    write_reg(siphash_pkg::REG_KEY_LOW, {$urandom, $urandom});
    write_reg(siphash_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(REG_SPARE_LOW, {$urandom, $urandom});
    run_random_messages(ITEMS_PER_PHASE);

    send_idle_pct  = 54;
    recv_idle_pct <= 9;
    write_reg(siphash_pkg::REG_KEY_LOW, '0);
    write_reg(siphash_pkg::REG_KEY_HIGH, '1);
    run_random_messages(ITEMS_PER_PHASE);

    send_idle_pct  = 0;
    recv_idle_pct <= 0;
    write_reg(siphash_pkg::REG_KEY_HIGH, {$urandom, $urandom});
    write_reg(siphash_pkg::REG_KEY_LOW, {$urandom, $urandom});
    // The receiver stalls for a long stretch so the job queue backs up into the input.
    hold_asked <= hold_asked + 1;
    run_random_messages(ITEMS_PER_PHASE);

    in_if.valid <= 1'b0;
    while (hash_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
